// File: design/twsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared constants, types and state codes of the touch window smoother.
// ----------------------------------------------------------------------------
package twsm_pkg;

    localparam int WINDOW  = 8;
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SUM_W   = $clog2(WINDOW * 255 + 1);
    localparam int DSTEP_W = $clog2(SUM_W + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_LIFT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// File: design/twsm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_front
// Accepts frame ticks and classifies them into queue commands.
// ----------------------------------------------------------------------------
module twsm_front
    import twsm_pkg::*;
(
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_touch_down,
    input  wire logic       s_touch_lifted,
    input  wire logic [7:0] s_pos_x,
    input  wire logic [7:0] s_pos_y,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    // touched and lifted together: the touch wins
    always_comb begin
        s_ready     = !q_full;
        q_push      = s_valid && !q_full;
        q_cmd.pos_x = s_pos_x;
        q_cmd.pos_y = s_pos_y;
        if (s_touch_down) begin
            q_cmd.op = OP_PUSH;
        end else if (s_touch_lifted) begin
            q_cmd.op = OP_LIFT;
        end else begin
            q_cmd.op = OP_NONE;
        end
    end

endmodule
`default_nettype wire

// File: design/twsm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module twsm_queue
    import twsm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      pop_valid,
    input  wire logic pop,
    output cmd_t      pop_cmd
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    always_comb begin
        full      = (cnt_reg == QCNT_W'(QDEPTH));
        pop_valid = (cnt_reg != '0);
        pop_cmd   = slot_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && pop_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: design/twsm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twsm_back
// Window update, serial sum over stored samples, serial divide, result register.
// ----------------------------------------------------------------------------
module twsm_back
    import twsm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    output logic            q_pop,
    input  wire cmd_t       q_cmd,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_pressed,
    output logic            m_pressed_solid,
    output logic            m_held,
    output logic            m_released,
    output logic            m_avg_valid,
    output logic [7:0]      m_avg_x,
    output logic [7:0]      m_avg_y
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               rel_pend_reg, rel_pend_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   rd_left_reg, rd_left_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]   acc_x_reg, acc_x_next;
    logic [SUM_W-1:0]   acc_y_reg, acc_y_next;
    logic [CNT_W-1:0]   rem_x_reg, rem_x_next;
    logic [CNT_W-1:0]   rem_y_reg, rem_y_next;
    logic [DSTEP_W-1:0] step_reg, step_next;
    logic               pressed_reg, pressed_next;
    logic               solid_reg, solid_next;
    logic               held_reg, held_next;
    logic               released_reg, released_next;
    logic               avg_valid_reg, avg_valid_next;

    logic [7:0]         mem_x [WINDOW];
    logic [7:0]         mem_y [WINDOW];
    logic [7:0]         rd_x_reg, rd_y_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_idx;

    logic [CNT_W-1:0]   cnt0, cnt_new;
    logic [IDX_W-1:0]   head_new;
    logic               was_full;
    logic [IDX_W:0]     tail_sum;
    logic [CNT_W:0]     trial_x, trial_y, div_ext;
    logic               ge_x, ge_y;

    // window update on a popped command
    always_comb begin
        cnt0     = rel_pend_reg ? '0 : count_reg;
        was_full = (cnt0 == CNT_W'(WINDOW));
        tail_sum = (IDX_W + 1)'(head_reg) + (IDX_W + 1)'(cnt0);
        if (tail_sum >= (IDX_W + 1)'(WINDOW)) begin
            tail_sum = tail_sum - (IDX_W + 1)'(WINDOW);
        end
        head_new = head_reg;
        cnt_new  = cnt0;
        wr_idx   = tail_sum[IDX_W-1:0];
        if (q_cmd.op == OP_PUSH) begin
            if (was_full) begin
                wr_idx   = head_reg;
                head_new = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;
            end else begin
                cnt_new = cnt0 + 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = (cnt_new == '0) ? ST_OUT : ST_SUM;
                end
            end
            ST_SUM: begin
                if (rd_left_reg == '0 && !rd_pend_reg) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == DSTEP_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop   = 1'b0;
        m_valid = 1'b0;
        mem_we  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop  = q_valid;
                mem_we = q_valid && (q_cmd.op == OP_PUSH);
            end
            ST_OUT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        div_ext = {1'b0, count_reg};
        trial_x = {rem_x_reg, acc_x_reg[SUM_W-1]};
        trial_y = {rem_y_reg, acc_y_reg[SUM_W-1]};
        ge_x    = (trial_x >= div_ext);
        ge_y    = (trial_y >= div_ext);

        count_next     = count_reg;
        head_next      = head_reg;
        rel_pend_next  = rel_pend_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_left_next   = rd_left_reg;
        rd_pend_next   = 1'b0;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        step_next      = step_reg;
        pressed_next   = pressed_reg;
        solid_next     = solid_reg;
        held_next      = held_reg;
        released_next  = released_reg;
        avg_valid_next = avg_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    count_next     = cnt_new;
                    head_next      = head_new;
                    rel_pend_next  = (q_cmd.op == OP_LIFT);
                    rd_ptr_next    = head_new;
                    rd_left_next   = cnt_new;
                    acc_x_next     = '0;
                    acc_y_next     = '0;
                    pressed_next   = (q_cmd.op == OP_PUSH) && !was_full
                                     && (cnt_new == CNT_W'(2));
                    solid_next     = (q_cmd.op == OP_PUSH) && !was_full
                                     && (cnt_new == CNT_W'(WINDOW));
                    held_next      = (cnt_new == CNT_W'(WINDOW));
                    released_next  = (q_cmd.op == OP_LIFT);
                    avg_valid_next = (cnt_new != '0);
                end
            end
            ST_SUM: begin
                if (rd_left_reg != '0) begin
                    rd_left_next = rd_left_reg - 1'b1;
                    rd_pend_next = 1'b1;
                    rd_ptr_next  = (rd_ptr_reg == IDX_W'(WINDOW - 1)) ? '0
                                   : rd_ptr_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    acc_x_next = acc_x_reg + SUM_W'(rd_x_reg);
                    acc_y_next = acc_y_reg + SUM_W'(rd_y_reg);
                end
                rem_x_next = '0;
                rem_y_next = '0;
                step_next  = DSTEP_W'(SUM_W);
            end
            ST_DIV: begin
                rem_x_next = ge_x ? CNT_W'(trial_x - div_ext) : trial_x[CNT_W-1:0];
                rem_y_next = ge_y ? CNT_W'(trial_y - div_ext) : trial_y[CNT_W-1:0];
                acc_x_next = {acc_x_reg[SUM_W-2:0], ge_x};
                acc_y_next = {acc_y_reg[SUM_W-2:0], ge_y};
                step_next  = step_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            rel_pend_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            rel_pend_reg <= rel_pend_next;
            rd_pend_reg  <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg    <= rd_ptr_next;
        rd_left_reg   <= rd_left_next;
        acc_x_reg     <= acc_x_next;
        acc_y_reg     <= acc_y_next;
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        step_reg      <= step_next;
        pressed_reg   <= pressed_next;
        solid_reg     <= solid_next;
        held_reg      <= held_next;
        released_reg  <= released_next;
        avg_valid_reg <= avg_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_x[wr_idx] <= q_cmd.pos_x;
            mem_y[wr_idx] <= q_cmd.pos_y;
        end
        rd_x_reg <= mem_x[rd_ptr_reg];
        rd_y_reg <= mem_y[rd_ptr_reg];
    end

    // quotient never exceeds 255; empty window leaves the cleared sums
    assign m_pressed       = pressed_reg;
    assign m_pressed_solid = solid_reg;
    assign m_held          = held_reg;
    assign m_released      = released_reg;
    assign m_avg_valid     = avg_valid_reg;
    assign m_avg_x         = acc_x_reg[7:0];
    assign m_avg_y         = acc_y_reg[7:0];

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW))
        else $error("sample count beyond window");

    a_held_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_held) |-> m_avg_valid)
        else $error("held without a valid average");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (rd_left_reg <= count_reg))
        else $error("sum reads beyond stored samples");

    a_div_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && $past(state_reg) == ST_SUM) |->
        (step_reg == DSTEP_W'(SUM_W) && count_reg != '0))
        else $error("divide started badly");
`endif

endmodule
`default_nettype wire

// File: design/touch_window_smoother_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_window_smoother_core
// Sliding-window touch smoother: edge flags and truncated mean of x,y samples.
// ----------------------------------------------------------------------------
// Flow: the queue registers each transfer in; the back pops it and updates the window, then
//   sums the stored samples serially through the window RAM read port (SUM_W = 11 at WINDOW 8)
//   and runs a bit-serial divide before the result is held for m_ready.
// Overlap: the back takes a new tick only after the last result is accepted; the queue
//   buffers up to QDEPTH ticks meanwhile. An empty window skips sum and divide.
// Reset: aresetn synchronous, active low; clears count, release flag, queue; RAM not cleared.
module touch_window_smoother_core
    import twsm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_touch_down,
    input  wire logic       s_touch_lifted,
    input  wire logic [7:0] s_pos_x,
    input  wire logic [7:0] s_pos_y,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_pressed,
    output logic            m_pressed_solid,
    output logic            m_held,
    output logic            m_released,
    output logic            m_avg_valid,
    output logic [7:0]      m_avg_x,
    output logic [7:0]      m_avg_y
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_pop_cmd;

    twsm_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_touch_down   (s_touch_down),
        .s_touch_lifted (s_touch_lifted),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_push_cmd)
    );

    twsm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (q_pop_cmd)
    );

    twsm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_cmd           (q_pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed       (m_pressed),
        .m_pressed_solid (m_pressed_solid),
        .m_held          (m_held),
        .m_released      (m_released),
        .m_avg_valid     (m_avg_valid),
        .m_avg_x         (m_avg_x),
        .m_avg_y         (m_avg_y)
    );

endmodule
`default_nettype wire

// File: test/touch_window_smoother_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_window_smoother_core_tb
// Drives frame ticks into the smoother and checks every result against a local
// sliding-window model: edge flags, the full-window flag and the truncated
// x,y means. Directed gestures first, then random touches with noise, with
// random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module touch_window_smoother_core_tb
    import twsm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_TICKS   = 2000;

    typedef struct packed {
        bit         touch_down;
        bit         touch_lifted;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        int         gap;
        bit         drain;
    } tick_t;

    typedef struct packed {
        bit         pressed;
        bit         pressed_solid;
        bit         held;
        bit         released;
        bit         avg_valid;
        logic [7:0] avg_x;
        logic [7:0] avg_y;
    } smooth_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_touch_down    = 1'b0;
    logic       s_touch_lifted  = 1'b0;
    logic [7:0] s_pos_x         = 8'd0;
    logic [7:0] s_pos_y         = 8'd0;
    logic       m_ready         = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic       m_pressed;
    logic       m_pressed_solid;
    logic       m_held;
    logic       m_released;
    logic       m_avg_valid;
    logic [7:0] m_avg_x;
    logic [7:0] m_avg_y;

    tick_t   pending_ticks[$];
    smooth_t expected_smooth[$];

    logic [7:0] model_x[WINDOW];
    logic [7:0] model_y[WINDOW];
    int         model_count = 0;
    bit         model_lift  = 1'b0;

    int  mismatches   = 0;
    int  ticks_sent   = 0;
    int  results_seen = 0;
    int  seen_pressed = 0;
    int  seen_solid   = 0;
    int  seen_held    = 0;
    int  seen_release = 0;
    int  idle_cycles  = 0;
    bit  tx_calm      = 1'b0;
    int  tx_waited    = 0;
    int  rx_stall     = 0;
    int  rx_calm_left = 0;
    tick_t tx_cur;

    touch_window_smoother_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_touch_down    (s_touch_down),
        .s_touch_lifted  (s_touch_lifted),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed       (m_pressed),
        .m_pressed_solid (m_pressed_solid),
        .m_held          (m_held),
        .m_released      (m_released),
        .m_avg_valid     (m_avg_valid),
        .m_avg_x         (m_avg_x),
        .m_avg_y         (m_avg_y)
    );

    always #2 aclk = ~aclk;

    // Window update and means for one frame tick.
    function automatic smooth_t smooth_tick(tick_t t);
        smooth_t r;
        int      sx;
        int      sy;
        bit      was_full;
        r        = '0;
        sx       = 0;
        sy       = 0;
        was_full = 1'b0;
        if (model_lift) begin
            model_count = 0;
        end
        model_lift = 1'b0;
        if (t.touch_down) begin
            if (model_count == WINDOW) begin
                for (int i = 0; i < WINDOW - 1; i++) begin
                    model_x[i] = model_x[i + 1];
                    model_y[i] = model_y[i + 1];
                end
                model_count = WINDOW - 1;
                was_full    = 1'b1;
            end
            model_x[model_count] = t.pos_x;
            model_y[model_count] = t.pos_y;
            model_count++;
            r.pressed       = !was_full && (model_count == 2);
            r.pressed_solid = !was_full && (model_count == WINDOW);
        end else if (t.touch_lifted) begin
            model_lift = 1'b1;
        end
        r.held     = (model_count == WINDOW);
        r.released = model_lift;
        if (model_count > 0) begin
            for (int i = 0; i < model_count; i++) begin
                sx += int'(model_x[i]);
                sy += int'(model_y[i]);
            end
            r.avg_valid = 1'b1;
            r.avg_x     = 8'(sx / model_count);
            r.avg_y     = 8'(sy / model_count);
        end
        return r;
    endfunction

    task automatic add_tick(bit down, bit lifted, logic [7:0] x, logic [7:0] y, bit drain);
        tick_t t;
        t.touch_down   = down;
        t.touch_lifted = lifted;
        t.pos_x        = x;
        t.pos_y        = y;
        t.gap          = tx_calm ? 0 : $urandom_range(0, 4);
        t.drain        = drain;
        pending_ticks.push_back(t);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        $display("%0t: result %0d %s got %0d want %0d", $realtime, results_seen, field,
                 got, want);
    endtask

    // Driver: presents the pending ticks, predicting each one on its transfer.
    always @(posedge aclk) begin : driver
        bit free;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            tx_waited  = 0;
        end else begin
            free = !s_valid || s_ready;
            if (s_valid && s_ready) begin
                expected_smooth.push_back(smooth_tick(tx_cur));
                ticks_sent++;
            end
            if (free) begin
                if (pending_ticks.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (tx_waited < pending_ticks[0].gap ||
                             (pending_ticks[0].drain && expected_smooth.size() != 0)) begin
                    tx_waited++;
                    s_valid <= 1'b0;
                end else begin
                    tx_cur          = pending_ticks.pop_front();
                    tx_waited       = 0;
                    s_valid        <= 1'b1;
                    s_touch_down   <= tx_cur.touch_down;
                    s_touch_lifted <= tx_cur.touch_lifted;
                    s_pos_x        <= tx_cur.pos_x;
                    s_pos_y        <= tx_cur.pos_y;
                end
            end
        end
    end

    // Monitor: random back-pressure, checks each result transfer.
    always @(posedge aclk) begin : monitor
        smooth_t want;
        bit      next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_smooth.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    want = expected_smooth.pop_front();
                    if (m_pressed !== want.pressed)
                        report_mismatch("pressed", int'(m_pressed), int'(want.pressed));
                    if (m_pressed_solid !== want.pressed_solid)
                        report_mismatch("pressed_solid", int'(m_pressed_solid),
                                        int'(want.pressed_solid));
                    if (m_held !== want.held)
                        report_mismatch("held", int'(m_held), int'(want.held));
                    if (m_released !== want.released)
                        report_mismatch("released", int'(m_released), int'(want.released));
                    if (m_avg_valid !== want.avg_valid)
                        report_mismatch("avg_valid", int'(m_avg_valid), int'(want.avg_valid));
                    if (m_avg_x !== want.avg_x)
                        report_mismatch("avg_x", int'(m_avg_x), int'(want.avg_x));
                    if (m_avg_y !== want.avg_y)
                        report_mismatch("avg_y", int'(m_avg_y), int'(want.avg_y));
                end
                results_seen++;
                seen_pressed += int'(m_pressed);
                seen_solid   += int'(m_pressed_solid);
                seen_held    += int'(m_held);
                seen_release += int'(m_released);
                if (rx_calm_left > 0) begin
                    rx_calm_left--;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_calm_left = $urandom_range(20, 80);
                end
                rx_stall = (rx_calm_left > 0) ? 0 : $urandom_range(0, 4);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_ready <= next_ready;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int         added;
        int         len;
        int         spread;
        logic [7:0] cx;
        logic [7:0] cy;
        bit         drain_due;

        // lift with an empty window, then a quiet tick
        add_tick(1'b0, 1'b1, 8'h00, 8'h00, 1'b0);
        add_tick(1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0);
        // fill the window with extreme and alternating coordinates
        add_tick(1'b1, 1'b0, 8'h00, 8'hFF, 1'b0);
        add_tick(1'b1, 1'b0, 8'hFF, 8'h00, 1'b0);
        add_tick(1'b1, 1'b0, 8'hAA, 8'h55, 1'b0);
        add_tick(1'b1, 1'b0, 8'h55, 8'hAA, 1'b0);
        add_tick(1'b1, 1'b0, 8'hFF, 8'hFF, 1'b0);
        add_tick(1'b1, 1'b0, 8'hFF, 8'hFF, 1'b0);
        add_tick(1'b1, 1'b0, 8'hFF, 8'hFF, 1'b0);
        add_tick(1'b1, 1'b0, 8'hFE, 8'hFD, 1'b0);
        // touch and lift together: sample kept, window slides
        add_tick(1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0);
        add_tick(1'b1, 1'b0, 8'h80, 8'h7F, 1'b0);
        add_tick(1'b0, 1'b1, 8'h12, 8'h34, 1'b0);
        // new touch straight after a lift
        add_tick(1'b1, 1'b0, 8'h01, 8'h02, 1'b0);
        add_tick(1'b1, 1'b0, 8'h00, 8'h00, 1'b0);
        add_tick(1'b0, 1'b1, 8'h00, 8'h00, 1'b0);
        add_tick(1'b0, 1'b1, 8'h00, 8'h00, 1'b0);
        add_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
        add_tick(1'b1, 1'b0, 8'h7F, 8'h80, 1'b1);
        add_tick(1'b0, 1'b1, 8'h00, 8'h00, 1'b0);

        added     = 0;
        drain_due = 1'b0;
        while (added < RANDOM_TICKS) begin
            tx_calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 8) begin
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 10);
                spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 15);
                cx     = 8'($urandom);
                cy     = 8'($urandom);
                for (int i = 0; i < len; i++) begin
                    add_tick(1'b1, $urandom_range(0, 15) == 0,
                             cx ^ 8'($urandom_range(0, spread)),
                             cy ^ 8'($urandom_range(0, spread)), drain_due);
                    drain_due = 1'b0;
                end
                added += len;
                if ($urandom_range(0, 9) != 0) begin
                    add_tick(1'b0, 1'b1, 8'($urandom), 8'($urandom), 1'b0);
                    added++;
                end
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) begin
                    add_tick(1'b0, 1'b0, 8'($urandom), 8'($urandom), 1'b0);
                end
                added += len;
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    add_tick(1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                             1'b0);
                end
                added += len;
            end
            if ($urandom_range(0, 99) == 0) begin
                drain_due = 1'b1;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ticks.size() != 0 || s_valid) @(posedge aclk);
        while (expected_smooth.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d ticks, checked %0d results with random gaps and stalls.",
                 ticks_sent, results_seen);
        $display("Flags seen: pressed %0d, solid %0d, held %0d, released %0d.",
                 seen_pressed, seen_solid, seen_held, seen_release);
        if (mismatches == 0 && expected_smooth.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/twsm_pkg.sv
design/twsm_front.sv
design/twsm_queue.sv
design/twsm_back.sv
design/touch_window_smoother_core.sv
test/touch_window_smoother_core_tb.sv
